// File: rtl/ckb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and the color conversion for the color-keyed blitter.
// No dependencies; imported by the blitter core and its checker.
package ckb_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int SIZE_W   = 12;  // image size registers and pixel counters
  localparam int CENTER_W = 14;  // signed center coordinates
  localparam int POS_W    = 15;  // signed on-screen position of a pixel
  localparam int ADDR_W   = 19;
  localparam int COLOR_W  = 16;
  localparam int CHAN_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);

  localparam int IN_DATA_W  = 24;  // three channels
  localparam int OUT_DATA_W = 40;  // 35 bits of fields padded to whole bytes

  localparam logic [ADDR_W-1:0]  SCREEN_PIXELS = ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam logic [COLOR_W-1:0] KEY_COLOR   = 16'hFFFF;
  localparam logic [COLOR_W-1:0] SUBST_COLOR = 16'hF7DE;
  localparam logic [CHAN_W-1:0]  CHAN_FULL   = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 2'd3;

  // RGB888 to RGB565. A full white made from channels below 0xFF is nudged off the key.
  function automatic logic [COLOR_W-1:0] to_rgb565(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
    logic [COLOR_W-1:0] c;
    c = {r[7:3], g[7:2], b[7:3]};
    if (r != CHAN_FULL && g != CHAN_FULL && b != CHAN_FULL && c == KEY_COLOR) begin
      c = SUBST_COLOR;
    end
    return c;
  endfunction

endpackage

// File: rtl/color_keyed_rgb565_blitter_core.sv
`timescale 1ns / 1ps
// Path: an accepted pixel is registered in stage A and then in the output register (stage B),
// from which its framebuffer write is offered.
// Throughput: one pixel per cycle while the sink takes writes. A write held by the sink blocks
// the source as soon as the pixel stage behind it is also occupied.
// Reset (rst, synchronous, active high) empties both stages, zeroes the pixel counters
// and returns the registers to width 1, height 1 and center (0, 0).
// Depends on ckb_pkg for constants and the RGB565 conversion.
module color_keyed_rgb565_blitter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ckb_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // red, green, blue
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ckb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // pixel_address, pixel_color, zeros
  input  logic                            cfg_we,
  input  logic [ckb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ckb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ckb_pkg::*;

  logic [SIZE_W-1:0]          image_width;
  logic [SIZE_W-1:0]          image_height;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;

  logic [SIZE_W-1:0] column_count, column_count_next;
  logic [SIZE_W-1:0] row_count, row_count_next;

  // Stage A: converted color and on-screen position.
  logic                    a_valid;
  logic [COLOR_W-1:0]      a_color;
  logic signed [POS_W-1:0] a_col;
  logic signed [POS_W-1:0] a_row;

  // Stage B: the output register.
  logic [ADDR_W-1:0]  out_addr;
  logic [COLOR_W-1:0] out_color;

  logic in_xfer, a_advance, a_visible;
  logic signed [POS_W-1:0] col_in, row_in;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic [ADDR_W-1:0] addr_calc;

  assign a_advance     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !a_valid || a_advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Top-left of the image sits at center minus half the size, rounded down.
  assign col_in = POS_W'(center_x) - POS_W'(image_width >> 1) + POS_W'(column_count);
  assign row_in = POS_W'(center_y) - POS_W'(image_height >> 1) + POS_W'(row_count);

  always_comb begin
    col_inc           = column_count + 1'b1;
    row_inc           = row_count + 1'b1;
    column_count_next = col_inc;
    row_count_next    = row_count;
    // A zero size compares as always reached, so it behaves as a size of one.
    if (col_inc >= image_width || col_inc == '0) begin
      column_count_next = '0;
      row_count_next    = row_inc;
      if (row_inc >= image_height || row_inc == '0) begin
        row_count_next = '0;
      end
    end
  end

  assign a_visible = (a_col >= 0) && (a_col < POS_W'(SCREEN_WIDTH)) &&
                     (a_row >= 0) && (a_row < POS_W'(SCREEN_HEIGHT)) &&
                     (a_color != KEY_COLOR);

  assign addr_calc = ADDR_W'(a_row[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH) +
                     ADDR_W'(a_col[COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(1);
      image_height <= SIZE_W'(1);
      center_x     <= '0;
      center_y     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        REG_CENTER_X:     center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      a_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_xfer) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (s_axis_tready) begin
        a_valid <= in_xfer;
      end
      // Clipped and transparent pixels leave stage A without a transfer.
      if (a_advance) begin
        m_axis_tvalid <= a_valid && a_visible;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_color <= to_rgb565(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
      a_col   <= col_in;
      a_row   <= row_in;
    end
    if (a_advance && a_valid && a_visible) begin
      out_addr  <= addr_calc;
      out_color <= a_color;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - ADDR_W - COLOR_W)'(0), out_color, out_addr};

endmodule

// File: rtl/ckb_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the color-keyed blitter core, bound into the blitter core.
// Depends on ckb_pkg for the key color and the framebuffer size.
module ckb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ckb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import ckb_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A stalled transfer keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // The transparent key never reaches the framebuffer.
  a_no_key: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[34:19] != KEY_COLOR)
    else $error("transparent color written");

  // Clipping keeps every write inside the framebuffer.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:0] < SCREEN_PIXELS)
    else $error("write address outside the framebuffer");

endmodule

bind color_keyed_rgb565_blitter_core ckb_checker u_ckb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb_color_keyed_rgb565_blitter_core.sv
`timescale 1ns / 1ps
// Testbench for color_keyed_rgb565_blitter_core. It streams RGB888 pixels under many image
// placements and sizes and checks every framebuffer write against its own blit model.
// Depends on ckb_pkg and the blitter core.
module tb_color_keyed_rgb565_blitter_core;
  import ckb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PIXELS = 360;

  // Red sits in the low byte of tdata, so it is the last member here.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb888_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } fb_write_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // red, green, blue
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // pixel_address, pixel_color, zeros
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Blit model state.
  logic [SIZE_W-1:0]          img_w = 12'd1;
  logic [SIZE_W-1:0]          img_h = 12'd1;
  logic signed [CENTER_W-1:0] ctr_x = '0;
  logic signed [CENTER_W-1:0] ctr_y = '0;
  logic [SIZE_W-1:0]          col_cnt = '0;
  logic [SIZE_W-1:0]          row_cnt = '0;

  rgb888_t   pixel_queue[$];
  fb_write_t fb_writes[$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  bit stall_request = 1'b0;
  bit stall_started = 1'b0;
  int src_wait = 0;
  int snk_wait = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int pixels_accepted = 0;
  int errors = 0;

  color_keyed_rgb565_blitter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Converts one source pixel, places it, queues the framebuffer write it should cause and
  // steps the raster counters.
  task automatic blit_pixel(input rgb888_t p);
    logic [COLOR_W-1:0] c;
    int col;
    int row;
    fb_write_t wr;
    c = (COLOR_W'(p.red >> 3) << 11) | (COLOR_W'(p.green >> 2) << 5) | COLOR_W'(p.blue >> 3);
    // Near-white that did not come from a full channel must not turn into the key.
    if (c == KEY_COLOR && p.red != CHAN_FULL && p.green != CHAN_FULL && p.blue != CHAN_FULL) begin
      c = SUBST_COLOR;
    end
    col = int'(ctr_x) - int'(img_w / 2) + int'(col_cnt);
    row = int'(ctr_y) - int'(img_h / 2) + int'(row_cnt);
    if (col >= 0 && col < SCREEN_WIDTH && row >= 0 && row < SCREEN_HEIGHT &&
        c != KEY_COLOR) begin
      wr.addr = ADDR_W'(row * SCREEN_WIDTH + col);
      wr.color = c;
      fb_writes.push_back(wr);
    end
    // A size of zero behaves as one, and a counter past a shrunken size wraps at once.
    col_cnt = col_cnt + 1'b1;
    if (col_cnt >= img_w || col_cnt == 0) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
      if (row_cnt >= img_h || row_cnt == 0) begin
        row_cnt = '0;
      end
    end
  endtask

  // Both transfers are observed at the rising edge.
  always @(posedge clk) begin
    fb_write_t want;
    logic [ADDR_W-1:0] got_addr;
    logic [COLOR_W-1:0] got_color;
    in_fire = !rst && s_axis_tvalid && s_axis_tready;
    out_fire = !rst && m_axis_tvalid && m_axis_tready;
    got_addr = m_axis_tdata[ADDR_W-1:0];
    got_color = m_axis_tdata[ADDR_W +: COLOR_W];
    if (out_fire) begin
      if (fb_writes.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("unexpected write: addr %0d color %h", got_addr, got_color);
        end
        errors++;
      end else begin
        want = fb_writes.pop_front();
        if (want.addr !== got_addr || want.color !== got_color) begin
          if (errors < MAX_REPORTS) begin
            $display("write mismatch: expected addr %0d color %h, got addr %0d color %h",
                     want.addr, want.color, got_addr, got_color);
          end
          errors++;
        end
      end
    end
    if (in_fire) begin
      blit_pixel(rgb888_t'(s_axis_tdata));
      pixels_accepted++;
    end
  end

  // Pixel source: while src_idle is set, it may idle after each transfer before the next pixel.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_wait = 0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_fire) begin
        src_wait = src_idle ? $urandom_range(0, 8) : 0;
      end
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        s_axis_tdata <= pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Write sink: random back-pressure per write while snk_idle is set, plus one long hold when asked.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (stall_request && !stall_started) begin
        stall_started = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (out_fire) begin
        snk_wait = snk_idle ? $urandom_range(0, 8) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w = value[SIZE_W-1:0];
      end
      REG_IMAGE_HEIGHT: begin
        img_h = value[SIZE_W-1:0];
      end
      REG_CENTER_X: begin
        ctr_x = value;
      end
      default: begin
        ctr_y = value;
      end
    endcase
  endtask

  // Unused upper data bits of the size registers get random values; they must be ignored.
  task automatic place_image(input int w, input int h, input int cx, input int cy);
    write_reg(REG_IMAGE_WIDTH, {2'($urandom), 12'(w)});
    write_reg(REG_IMAGE_HEIGHT, {2'($urandom), 12'(h)});
    write_reg(REG_CENTER_X, 14'(cx));
    write_reg(REG_CENTER_Y, 14'(cy));
    @(posedge clk);
  endtask

  task automatic push_pixel(input rgb888_t p);
    pixel_queue.push_back(p);
    pixels_sent++;
  endtask

  task automatic push_rgb(input int r, input int g, input int b);
    push_pixel({8'(b), 8'(g), 8'(r)});
  endtask

  // Waits until every pixel is taken and every write has arrived, then lets the pipe settle.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pixels_accepted != pixels_sent || fb_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic rgb888_t random_pixel();
    rgb888_t p;
    case ($urandom_range(0, 7))
      0: begin
        // Near white: lands on the key or on the substitute color.
        p.red = 8'(8'hF8 + $urandom_range(0, 7));
        p.green = 8'(8'hFC + $urandom_range(0, 3));
        p.blue = 8'(8'hF8 + $urandom_range(0, 7));
      end
      1: begin
        p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        p = 24'($urandom);
      end
    endcase
    return p;
  endfunction

  function automatic int random_size(input int typical);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(0, 1) ? 0 : 4095;
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  function automatic int random_center(input int screen);
    case ($urandom_range(0, 7))
      0: return int'($urandom_range(0, 16383)) - 8192;
      1: return int'($urandom_range(0, 4)) - 2;
      2: return screen - 3 + int'($urandom_range(0, 5));
      default: return $urandom_range(0, screen - 1);
    endcase
  endfunction

  initial begin
    int count;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset placement puts a 1x1 image at the origin: pure color checks.
    @(posedge clk);
    push_rgb(0, 0, 0);
    push_rgb(255, 255, 255);
    push_rgb(248, 252, 248);
    push_rgb(254, 253, 249);
    push_rgb(255, 252, 248);
    push_rgb(248, 255, 248);
    push_rgb(255, 0, 0);
    push_rgb(0, 255, 0);
    push_rgb(0, 0, 255);
    push_rgb(7, 3, 7);
    push_rgb(170, 85, 170);
    drain();

    // Top-left clip: the first row and first column fall off the screen.
    place_image(3, 2, 0, 0);
    repeat (6) push_pixel(random_pixel());
    drain();

    // Bottom-right clip: only the very last framebuffer pixel is visible.
    place_image(2, 2, SCREEN_WIDTH, SCREEN_HEIGHT);
    repeat (4) push_rgb(16, 32, 64);
    drain();

    // Long sink hold while the source streams without gaps, so the input backs up.
    place_image(16, 8, 320, 240);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    stall_request = 1'b1;
    repeat (64) push_pixel(random_pixel());
    drain();
    src_idle = 1'b1;
    snk_idle = 1'b1;

    place_image(0, 0, 5, 5);
    repeat (12) push_pixel(random_pixel());
    drain();

    place_image(4095, 4095, 8191, -8192);
    repeat (10) push_pixel(random_pixel());
    drain();

    place_image(4095, 4095, 2047, 2100);
    repeat (30) push_pixel(random_pixel());
    drain();

    count = 0;
    while (count < RANDOM_PIXELS) begin
      place_image(random_size(24), random_size(12), random_center(SCREEN_WIDTH),
                  random_center(SCREEN_HEIGHT));
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(8, 48)) begin
        push_pixel(random_pixel());
        count++;
      end
      drain();
    end

    if (errors == 0 && fb_writes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
